// ----- rtl/pcc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants for the CORDIC polar/Cartesian converter
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int DATA_W         = 51;
    localparam int ANGLE_W        = 34;
    localparam int GUARD          = 16;
    localparam int PRESCALE_SHIFT = 14;
    localparam int ARC_LEN        = 30;

    localparam logic signed [32:0] INV_GAIN    = 33'sd652032874;
    localparam logic signed [32:0] RAD_TO_TURN = 33'sd2734261102;
    localparam logic signed [32:0] DEG_TO_TURN = 33'sd3054198966;
    localparam logic signed [32:0] TWO_PI_Q29  = 33'sd3373259426;

    localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 34'sd1073741824;

    typedef logic [31:0] pcc_arc_t;

    // arctangent of 2^-i in binary-angle units, 2^32 per turn
    localparam pcc_arc_t ARC_TABLE [ARC_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458908, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    typedef enum logic [1:0] {
        AXIS_ZERO,
        AXIS_HALF,
        AXIS_POS_QUARTER,
        AXIS_NEG_QUARTER
    } pcc_axis_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_WIDE = 2'd1,
        STATUS_SAT  = 2'd2
    } pcc_status_t;

    typedef struct packed {
        logic                      rot;
        logic                      deg;
        logic                      wide;
        logic                      axis;
        pcc_axis_t                 axis_kind;
        logic [31:0]               axis_mag;
        logic signed [DATA_W-1:0]  x;
        logic signed [DATA_W-1:0]  y;
        logic signed [ANGLE_W-1:0] z;
    } pcc_work_t;

endpackage

// ----- rtl/pcc_front.sv -----
// ----------------------------------------------------------------------------
// pcc_front
// Gain prescale, angle to binary-angle conversion and quadrant folding
// ----------------------------------------------------------------------------
module pcc_front #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic signed [31:0]  first_value,
    input  logic signed [31:0]  second_value,
    input  logic                deg_mode,
    output logic                out_valid,
    input  logic                out_stall,
    output pcc_pkg::pcc_work_t  work
);
    import pcc_pkg::*;

    localparam logic signed [32:0] WIDE_LIMIT = 33'(TWO_PI_Q29 >>> (29 - FRACTION_BITS));

    logic                     s1_valid_reg;
    logic                     s1_rot_reg;
    logic                     s1_deg_reg;
    logic                     s1_wide_reg;
    logic                     s1_axis_reg;
    pcc_axis_t                s1_axis_kind_reg;
    logic [31:0]              s1_axis_mag_reg;
    logic                     s1_q_neg_reg;
    logic signed [63:0]       s1_prod_p_reg;
    logic signed [63:0]       s1_prod_q_reg;
    logic signed [63:0]       s1_prod_a_reg;

    logic                     s1_wide_next;
    logic                     s1_axis_next;
    pcc_axis_t                s1_axis_kind_next;
    logic [31:0]              s1_axis_mag_next;
    logic signed [63:0]       s1_prod_p_next;
    logic signed [63:0]       s1_prod_q_next;
    logic signed [63:0]       s1_prod_a_next;
    logic [31:0]              p_mag;
    logic [31:0]              q_mag;
    logic signed [32:0]       q_ext;
    logic                     s1_stall;

    logic                     s2_valid_reg;
    pcc_work_t                work_reg;
    pcc_work_t                work_next;
    logic signed [DATA_W-1:0] x_pre;
    logic signed [DATA_W-1:0] y_pre;
    logic [31:0]              turn;
    logic signed [ANGLE_W-1:0] z_turn;
    logic                     s2_stall;

    // stage 1: multiplications
    always_comb
    begin
        p_mag = first_value[31] ? (~first_value + 32'd1) : first_value;
        q_mag = second_value[31] ? (~second_value + 32'd1) : second_value;
        q_ext = 33'(second_value);
        s1_axis_next = command && (first_value == 32'sd0 || second_value == 32'sd0);
        if (second_value == 32'sd0)
        begin
            s1_axis_kind_next = first_value[31] ? AXIS_HALF : AXIS_ZERO;
            s1_axis_mag_next  = p_mag;
        end
        else
        begin
            s1_axis_kind_next = second_value[31] ? AXIS_NEG_QUARTER : AXIS_POS_QUARTER;
            s1_axis_mag_next  = q_mag;
        end
        s1_wide_next   = !command && !deg_mode && (q_ext > WIDE_LIMIT || q_ext < -WIDE_LIMIT);
        s1_prod_p_next = 64'(first_value) * 64'(INV_GAIN);
        s1_prod_q_next = 64'(second_value) * 64'(INV_GAIN);
        s1_prod_a_next = 64'(second_value) * 64'(deg_mode ? DEG_TO_TURN : RAD_TO_TURN);
    end

    assign s1_stall = s1_valid_reg && s2_stall;
    assign in_stall = s1_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s1_stall && in_valid)
        begin
            s1_rot_reg       <= !command;
            s1_deg_reg       <= deg_mode;
            s1_wide_reg      <= s1_wide_next;
            s1_axis_reg      <= s1_axis_next;
            s1_axis_kind_reg <= s1_axis_kind_next;
            s1_axis_mag_reg  <= s1_axis_mag_next;
            s1_q_neg_reg     <= second_value[31];
            s1_prod_p_reg    <= s1_prod_p_next;
            s1_prod_q_reg    <= s1_prod_q_next;
            s1_prod_a_reg    <= s1_prod_a_next;
        end
    end

    // stage 2: scaling, quadrant folding
    always_comb
    begin
        x_pre = DATA_W'(s1_prod_p_reg >>> PRESCALE_SHIFT);
        y_pre = DATA_W'(s1_prod_q_reg >>> PRESCALE_SHIFT);
        turn  = s1_deg_reg ? s1_prod_a_reg[FRACTION_BITS + 39 : FRACTION_BITS + 8]
                           : s1_prod_a_reg[FRACTION_BITS + 33 : FRACTION_BITS + 2];
        z_turn = ANGLE_W'($signed(turn));

        work_next           = '0;
        work_next.rot       = s1_rot_reg;
        work_next.deg       = s1_deg_reg;
        work_next.wide      = s1_wide_reg;
        work_next.axis      = s1_axis_reg;
        work_next.axis_kind = s1_axis_kind_reg;
        work_next.axis_mag  = s1_axis_mag_reg;
        if (s1_rot_reg)
        begin
            work_next.y = '0;
            priority if (z_turn > QUARTER_TURN)
            begin
                work_next.z = z_turn - HALF_TURN;
                work_next.x = -x_pre;
            end
            else if (z_turn < -QUARTER_TURN)
            begin
                work_next.z = z_turn + HALF_TURN;
                work_next.x = -x_pre;
            end
            else
            begin
                work_next.z = z_turn;
                work_next.x = x_pre;
            end
        end
        else if (x_pre[DATA_W-1])
        begin
            work_next.x = -x_pre;
            work_next.y = -y_pre;
            work_next.z = s1_q_neg_reg ? -HALF_TURN : HALF_TURN;
        end
        else
        begin
            work_next.x = x_pre;
            work_next.y = y_pre;
            work_next.z = '0;
        end
    end

    assign s2_stall = s2_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (!s2_stall)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s2_stall && s1_valid_reg)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign work      = work_reg;

endmodule

// ----- rtl/pcc_stage.sv -----
// ----------------------------------------------------------------------------
// pcc_stage
// One CORDIC micro-rotation, rotation or vectoring mode per request
// ----------------------------------------------------------------------------
module pcc_stage #(
    parameter int IDX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pcc_pkg::pcc_work_t work_in,
    output logic               out_valid,
    input  logic               out_stall,
    output pcc_pkg::pcc_work_t work_out
);
    import pcc_pkg::*;

    logic                      valid_reg;
    pcc_work_t                 work_reg;
    pcc_work_t                 work_next;
    logic signed [DATA_W-1:0]  dx;
    logic signed [DATA_W-1:0]  dy;
    logic signed [ANGLE_W-1:0] arc;
    logic                      sigma;

    always_comb
    begin
        dx    = work_in.x >>> IDX;
        dy    = work_in.y >>> IDX;
        arc   = $signed(ANGLE_W'(ARC_TABLE[IDX]));
        sigma = work_in.rot ? !work_in.z[ANGLE_W-1] : work_in.y[DATA_W-1];
        work_next = work_in;
        if (sigma)
        begin
            work_next.x = work_in.x - dy;
            work_next.y = work_in.y + dx;
            work_next.z = work_in.z - arc;
        end
        else
        begin
            work_next.x = work_in.x + dy;
            work_next.y = work_in.y - dx;
            work_next.z = work_in.z + arc;
        end
    end

    assign in_stall = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign work_out  = work_reg;

endmodule

// ----- rtl/pcc_back.sv -----
// ----------------------------------------------------------------------------
// pcc_back
// Angle unit scaling, rounding, saturation and output register
// ----------------------------------------------------------------------------
module pcc_back #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pcc_pkg::pcc_work_t work,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] first_result,
    output logic signed [31:0] second_result,
    output logic [1:0]         status
);
    import pcc_pkg::*;

    localparam int RX_W = DATA_W - GUARD;
    localparam logic signed [DATA_W-1:0] ROUND_X   = DATA_W'(1) <<< (GUARD - 1);
    localparam logic signed [63:0]       ROUND_RAD = 64'sd1 <<< (60 - FRACTION_BITS);
    localparam logic signed [63:0]       ROUND_DEG = 64'sd1 <<< (31 - FRACTION_BITS);

    function automatic logic [32:0] clamp64(input logic signed [63:0] v);
        logic [32:0] res;
        if (v > 64'sd2147483647)
        begin
            res = {1'b1, 32'h7FFF_FFFF};
        end
        else if (v < -64'sd2147483648)
        begin
            res = {1'b1, 32'h8000_0000};
        end
        else
        begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    logic                    a_valid_reg;
    logic                    a_rot_reg;
    logic                    a_wide_reg;
    logic                    a_axis_reg;
    logic [31:0]             a_axis_mag_reg;
    logic                    a_deg_reg;
    logic signed [RX_W-1:0]  a_rx_reg;
    logic signed [RX_W-1:0]  a_ry_reg;
    logic signed [63:0]      a_prod_reg;
    logic signed [ANGLE_W-1:0] z_lim;
    logic signed [32:0]      zc;
    logic signed [63:0]      a_prod_next;
    logic                    a_stall;

    logic                    b_valid_reg;
    logic signed [31:0]      first_result_reg;
    logic signed [31:0]      second_result_reg;
    pcc_status_t             status_reg;
    logic signed [63:0]      ang_round;
    logic [32:0]             r1;
    logic [32:0]             r2;
    logic                    sat;
    pcc_status_t             status_next;
    logic                    b_stall;

    // stage a: angle product and coordinate rounding add
    always_comb
    begin
        if (work.axis)
        begin
            unique case (work.axis_kind)
                AXIS_ZERO:        z_lim = '0;
                AXIS_HALF:        z_lim = HALF_TURN;
                AXIS_POS_QUARTER: z_lim = QUARTER_TURN;
                AXIS_NEG_QUARTER: z_lim = -QUARTER_TURN;
                default:          z_lim = '0;
            endcase
        end
        else if (work.z > HALF_TURN)
        begin
            z_lim = HALF_TURN;
        end
        else if (work.z < -HALF_TURN)
        begin
            z_lim = -HALF_TURN;
        end
        else
        begin
            z_lim = work.z;
        end
        zc = 33'(z_lim);
        a_prod_next = work.deg ? 64'(zc) * 64'sd360 : 64'(zc) * 64'(TWO_PI_Q29);
    end

    assign a_stall  = a_valid_reg && b_stall;
    assign in_stall = a_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (!a_stall)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!a_stall && in_valid)
        begin
            a_rot_reg      <= work.rot;
            a_wide_reg     <= work.wide;
            a_axis_reg     <= work.axis;
            a_axis_mag_reg <= work.axis_mag;
            a_deg_reg      <= work.deg;
            a_rx_reg       <= RX_W'((work.x + ROUND_X) >>> GUARD);
            a_ry_reg       <= RX_W'((work.y + ROUND_X) >>> GUARD);
            a_prod_reg     <= a_prod_next;
        end
    end

    // stage b: angle rounding, saturation, status
    always_comb
    begin
        ang_round = a_deg_reg ? ((a_prod_reg + ROUND_DEG) >>> (32 - FRACTION_BITS))
                              : ((a_prod_reg + ROUND_RAD) >>> (61 - FRACTION_BITS));
        r1 = a_axis_reg ? clamp64($signed(64'(a_axis_mag_reg))) : clamp64(64'(a_rx_reg));
        r2 = a_rot_reg ? clamp64(64'(a_ry_reg)) : clamp64(ang_round);
        sat = r1[32] || r2[32];
        priority if (sat)
        begin
            status_next = STATUS_SAT;
        end
        else if (a_wide_reg)
        begin
            status_next = STATUS_WIDE;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    assign b_stall = b_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (!b_stall)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!b_stall && a_valid_reg)
        begin
            first_result_reg  <= $signed(r1[31:0]);
            second_result_reg <= $signed(r2[31:0]);
            status_reg        <= status_next;
        end
    end

    assign out_valid     = b_valid_reg;
    assign first_result  = first_result_reg;
    assign second_result = second_result_reg;
    assign status        = status_reg;

endmodule

// ----- rtl/polar_cartesian_converter.sv -----
// ----------------------------------------------------------------------------
// polar_cartesian_converter
// Pipelined CORDIC converter between polar and Cartesian Q16.16 pairs
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  command, first_value, second_value
//  out       output     out_valid / out_stall first_result, second_result, status
//  cfg       input      cfg_valid / cfg_ready angle_in_degrees
//
//  one request per cycle while in_stall is low; the stages are:
//  two front stages, one stage per micro-rotation, two back stages
//  reset clears every stage valid bit and selects radians
//  a stall holds only the stages that are full; empty stages keep filling
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module polar_cartesian_converter #(
    parameter int ITERATIONS    = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic signed [31:0] first_value,
    input  logic signed [31:0] second_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] first_result,
    output logic signed [31:0] second_result,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               angle_in_degrees
);
    import pcc_pkg::*;

    logic      deg_reg;
    pcc_work_t work  [ITERATIONS+1];
    logic      valid [ITERATIONS+1];
    logic      stall [ITERATIONS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            deg_reg <= angle_in_degrees;
        end
    end

    pcc_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .first_value  (first_value),
        .second_value (second_value),
        .deg_mode     (deg_reg),
        .out_valid    (valid[0]),
        .out_stall    (stall[0]),
        .work         (work[0])
    );

    for (genvar k = 0; k < ITERATIONS; k++)
    begin : g_stage
        pcc_stage #(
            .IDX (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[k]),
            .in_stall  (stall[k]),
            .work_in   (work[k]),
            .out_valid (valid[k+1]),
            .out_stall (stall[k+1]),
            .work_out  (work[k+1])
        );
    end

    pcc_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (valid[ITERATIONS]),
        .in_stall      (stall[ITERATIONS]),
        .work          (work[ITERATIONS]),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .first_result  (first_result),
        .second_result (second_result),
        .status        (status)
    );

endmodule

// ----- rtl/pcc_checker.sv -----
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks for the polar/Cartesian converter, bound to the top
// ----------------------------------------------------------------------------
module pcc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               command,
    input logic signed [31:0] first_value,
    input logic signed [31:0] second_value,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] first_result,
    input logic signed [31:0] second_result,
    input logic [1:0]         status
);

    // input side backs up only when every stage is full and output is held
    a_stall_only_when_full: assert property (@(posedge clk)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while pipeline has room");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> (!out_valid && !in_stall))
        else $error("pipeline not empty during reset");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> (in_valid && $stable(command)
            && $stable(first_value) && $stable(second_value)))
        else $error("stalled request changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(first_result)
            && $stable(second_result) && $stable(status)))
        else $error("stalled result changed");

endmodule

bind polar_cartesian_converter pcc_checker u_pcc_checker (.*);

// ----- dv/tb_polar_cartesian_converter.sv -----
// ----------------------------------------------------------------------------
// tb_polar_cartesian_converter
// Self-checking bench for the CORDIC polar/Cartesian converter. Requests in
// both directions and both angle units go through a bit-exact fixed-point
// model of the micro-rotation datapath. Every result is compared field by
// field in order, with random input gaps and random output back-pressure.
// ----------------------------------------------------------------------------
module tb_polar_cartesian_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import pcc_pkg::*;

    localparam int ITERATIONS    = 24;
    localparam int FRACTION_BITS = 16;
    localparam int LATENCY       = ITERATIONS + 4;
    localparam int MAX_WAIT      = 13;
    localparam int GUARD_BITS    = 16;

    localparam bit CMD_TO_CARTESIAN = 1'b0;
    localparam bit CMD_TO_POLAR     = 1'b1;
    localparam bit UNIT_RADIANS     = 1'b0;
    localparam bit UNIT_DEGREES     = 1'b1;

    localparam longint GAIN_COMP        = 64'sd652032874;
    localparam longint TURN_PER_RAD     = 64'sd2734261102;
    localparam longint TURN_PER_DEG     = 64'sd3054198966;
    localparam longint RAD_PER_TURN_Q29 = 64'sd3373259426;
    localparam longint HALF_REV         = 64'sd2147483648;
    localparam longint QUARTER_REV      = 64'sd1073741824;
    localparam longint WORD_MAX         = 64'sd2147483647;
    localparam longint WORD_MIN         = -64'sd2147483648;
    localparam longint ANGLE_LIMIT      = RAD_PER_TURN_Q29 >>> (29 - FRACTION_BITS);

    localparam logic signed [31:0] Q_ONE   = 32'sd65536;
    localparam logic signed [31:0] Q_MAX   = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN   = 32'sh80000000;
    localparam logic signed [31:0] PI_Q16  = 32'sd205887;
    localparam logic signed [31:0] HPI_Q16 = 32'sd102944;
    localparam int                 DEG_SPAN = 360 * 65536;

    // arctangent of 2^-i, 2^32 units per turn
    localparam logic [0:29][31:0] ATAN_STEPS = {
        32'd536870912, 32'd316933406, 32'd167458908, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    typedef struct packed {
        logic [31:0] first_word;
        logic [31:0] second_word;
        pcc_status_t code;
    } conversion_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               command;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] first_result;
    logic signed [31:0] second_result;
    logic [1:0]         status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               angle_in_degrees;

    conversion_t pending_conversions[$];
    bit          degree_mode;
    bit          in_steady;
    bit          out_steady;
    int          error_count;
    int          results_seen;

    always #6 clk = ~clk;

    polar_cartesian_converter #(
        .ITERATIONS    (ITERATIONS),
        .FRACTION_BITS (FRACTION_BITS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .first_value      (first_value),
        .second_value     (second_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .first_result     (first_result),
        .second_result    (second_result),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .angle_in_degrees (angle_in_degrees)
    );

    function automatic longint round_half_up(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_word(longint v, inout bit sat);
        if (v > WORD_MAX)
        begin
            sat = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN)
        begin
            sat = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    function automatic longint gain_prescale(longint v);
        return (v * GAIN_COMP) >>> (30 - GUARD_BITS);
    endfunction

    function automatic longint angle_in_unit(longint z, bit deg, inout bit sat);
        longint zc;
        zc = (z > HALF_REV) ? HALF_REV : ((z < -HALF_REV) ? -HALF_REV : z);
        if (deg)
            return clamp_word(round_half_up(zc * 360, 32 - FRACTION_BITS), sat);
        return clamp_word(round_half_up(zc * RAD_PER_TURN_Q29, 61 - FRACTION_BITS), sat);
    endfunction

    function automatic conversion_t convert_pair(bit cmd, logic signed [31:0] a,
                                                 logic signed [31:0] b, bit deg);
        longint      p;
        longint      q;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        longint      r1;
        longint      r2;
        logic [63:0] product;
        logic [31:0] turn;
        bit          sat;
        bit          wide;
        conversion_t res;
        p    = longint'(a);
        q    = longint'(b);
        sat  = 1'b0;
        wide = 1'b0;
        if (cmd == CMD_TO_CARTESIAN)
        begin
            if (deg)
            begin
                product = q * TURN_PER_DEG;
                turn    = product[FRACTION_BITS + 8 +: 32];
            end
            else
            begin
                product = q * TURN_PER_RAD;
                turn    = product[FRACTION_BITS + 2 +: 32];
                wide    = (q > ANGLE_LIMIT) || (q < -ANGLE_LIMIT);
            end
            z = longint'($signed(turn));
            x = gain_prescale(p);
            y = 0;
            if (z > QUARTER_REV)
            begin
                z = z - HALF_REV;
                x = -x;
            end
            else if (z < -QUARTER_REV)
            begin
                z = z + HALF_REV;
                x = -x;
            end
            for (int i = 0; i < ITERATIONS; i++)
            begin
                dx = x >>> i;
                dy = y >>> i;
                if (z >= 0)
                begin
                    x = x - dy;
                    y = y + dx;
                    z = z - longint'(ATAN_STEPS[i]);
                end
                else
                begin
                    x = x + dy;
                    y = y - dx;
                    z = z + longint'(ATAN_STEPS[i]);
                end
            end
            r1 = clamp_word(round_half_up(x, GUARD_BITS), sat);
            r2 = clamp_word(round_half_up(y, GUARD_BITS), sat);
        end
        else if (q == 0)
        begin
            r1 = clamp_word((p < 0) ? -p : p, sat);
            r2 = (p < 0) ? angle_in_unit(HALF_REV, deg, sat) : 0;
        end
        else if (p == 0)
        begin
            r1 = clamp_word((q < 0) ? -q : q, sat);
            r2 = angle_in_unit((q < 0) ? -QUARTER_REV : QUARTER_REV, deg, sat);
        end
        else
        begin
            x = gain_prescale(p);
            y = gain_prescale(q);
            z = 0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = (q >= 0) ? HALF_REV : -HALF_REV;
            end
            for (int i = 0; i < ITERATIONS; i++)
            begin
                dx = x >>> i;
                dy = y >>> i;
                if (y >= 0)
                begin
                    x = x + dy;
                    y = y - dx;
                    z = z + longint'(ATAN_STEPS[i]);
                end
                else
                begin
                    x = x - dy;
                    y = y + dx;
                    z = z - longint'(ATAN_STEPS[i]);
                end
            end
            r1 = clamp_word(round_half_up(x, GUARD_BITS), sat);
            r2 = angle_in_unit(z, deg, sat);
        end
        res.first_word  = r1[31:0];
        res.second_word = r2[31:0];
        res.code        = sat ? STATUS_SAT : (wide ? STATUS_WIDE : STATUS_OK);
        return res;
    endfunction

    function automatic logic signed [31:0] random_magnitude();
        return $signed($urandom()) >>> $urandom_range(0, 31);
    endfunction

    function automatic logic signed [31:0] random_angle();
        int span;
        span = degree_mode ? DEG_SPAN + 64 : int'(ANGLE_LIMIT) + 64;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        $display("ERROR: %s", msg);
    endtask

    task automatic send_request(bit cmd, logic signed [31:0] a, logic signed [31:0] b);
        int gap;
        if ($urandom_range(0, 39) == 0)
            in_steady = !in_steady;
        gap = in_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        first_value  <= a;
        second_value <= b;
        do @(posedge clk); while (in_stall);
        pending_conversions.push_back(convert_pair(cmd, a, b, degree_mode));
    endtask

    task automatic write_angle_unit(bit unit);
        cfg_valid        <= 1'b1;
        angle_in_degrees <= unit;
        do @(posedge clk); while (!cfg_ready);
        degree_mode = unit;
        cfg_valid <= 1'b0;
    endtask

    task automatic finish_phase();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_conversions.size() > 0)
            @(posedge clk);
    endtask

    task automatic test_polar_to_cartesian_edges();
        send_request(CMD_TO_CARTESIAN, Q_ONE, 32'sd0);
        send_request(CMD_TO_CARTESIAN, Q_ONE, HPI_Q16);
        send_request(CMD_TO_CARTESIAN, Q_ONE, PI_Q16);
        send_request(CMD_TO_CARTESIAN, Q_MAX, -PI_Q16);
        send_request(CMD_TO_CARTESIAN, Q_MIN, 32'sd51472);
        send_request(CMD_TO_CARTESIAN, -Q_ONE, 32'(ANGLE_LIMIT));
        send_request(CMD_TO_CARTESIAN, Q_ONE, 32'(-ANGLE_LIMIT - 1));
        send_request(CMD_TO_CARTESIAN, 32'sd0, Q_MAX);
        send_request(CMD_TO_CARTESIAN, Q_MAX, Q_MIN);
    endtask

    task automatic test_cartesian_to_polar_edges();
        // origin, both axes, radius saturation
        send_request(CMD_TO_POLAR, 32'sd0, 32'sd0);
        send_request(CMD_TO_POLAR, Q_ONE, 32'sd0);
        send_request(CMD_TO_POLAR, -Q_ONE, 32'sd0);
        send_request(CMD_TO_POLAR, Q_MIN, 32'sd0);
        send_request(CMD_TO_POLAR, 32'sd0, -Q_ONE);
        send_request(CMD_TO_POLAR, 32'sd0, Q_MIN);
        send_request(CMD_TO_POLAR, Q_MAX, Q_MAX);
        send_request(CMD_TO_POLAR, Q_MIN, Q_MIN);
        send_request(CMD_TO_POLAR, -32'sd1, 32'sd1);
    endtask

    task automatic test_degree_angles();
        send_request(CMD_TO_CARTESIAN, Q_ONE, 32'sd90 <<< 16);
        send_request(CMD_TO_CARTESIAN, Q_ONE, -(32'sd180 <<< 16));
        send_request(CMD_TO_CARTESIAN, Q_MAX, Q_MIN);
        send_request(CMD_TO_POLAR, -Q_ONE, 32'sd0);
        send_request(CMD_TO_POLAR, 32'sd0, Q_ONE);
        send_request(CMD_TO_POLAR, 32'sd3 <<< 16, -(32'sd4 <<< 16));
    endtask

    task automatic test_random_traffic(int count);
        logic signed [31:0] a;
        logic signed [31:0] b;
        bit                 cmd;
        for (int n = 0; n < count; n++)
        begin
            cmd = 1'($urandom_range(0, 1));
            a   = random_magnitude();
            if (cmd == CMD_TO_CARTESIAN)
                b = ($urandom_range(0, 4) == 0) ? random_magnitude() : random_angle();
            else
            begin
                b = random_magnitude();
                // land on an axis now and then
                case ($urandom_range(0, 9))
                    0: a = 32'sd0;
                    1: b = 32'sd0;
                    default: ;
                endcase
            end
            send_request(cmd, a, b);
        end
    endtask

    initial
    begin : result_checker
        int          hold;
        conversion_t want;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_conversions.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with no request pending",
                                              results_seen));
                else
                begin
                    want = pending_conversions.pop_front();
                    if (first_result !== want.first_word)
                        report_mismatch($sformatf("result %0d first_result %h, want %h",
                                                  results_seen, first_result, want.first_word));
                    if (second_result !== want.second_word)
                        report_mismatch($sformatf("result %0d second_result %h, want %h",
                                                  results_seen, second_result, want.second_word));
                    if (status !== want.code)
                        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                                  results_seen, status, want.code));
                end
                if ($urandom_range(0, 39) == 0)
                    out_steady = !out_steady;
                hold = out_steady ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else if (hold > 0)
                hold--;
            out_stall <= (hold > 0);
        end
    end

    initial
    begin
        #8000000;
        $display("polar_cartesian_converter verification failed");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        command          = CMD_TO_CARTESIAN;
        first_value      = '0;
        second_value     = '0;
        cfg_valid        = 1'b0;
        angle_in_degrees = UNIT_RADIANS;
        degree_mode      = UNIT_RADIANS;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_angle_unit(UNIT_RADIANS);
        test_polar_to_cartesian_edges();
        finish_phase();
        test_cartesian_to_polar_edges();
        finish_phase();

        write_angle_unit(UNIT_DEGREES);
        test_degree_angles();
        finish_phase();
        test_random_traffic(500);
        finish_phase();

        write_angle_unit(UNIT_RADIANS);
        test_random_traffic(500);
        finish_phase();

        write_angle_unit(UNIT_DEGREES);
        test_random_traffic(200);
        finish_phase();

        write_angle_unit(UNIT_RADIANS);
        test_random_traffic(200);
        finish_phase();

        repeat (LATENCY + 12) @(posedge clk);
        if (error_count == 0)
            $display("polar_cartesian_converter verification clean");
        else
            $display("polar_cartesian_converter verification failed");
        $finish;
    end

endmodule

// ----- polar_cartesian_converter.f -----
rtl/pcc_pkg.sv
rtl/pcc_front.sv
rtl/pcc_stage.sv
rtl/pcc_back.sv
rtl/polar_cartesian_converter.sv
rtl/pcc_checker.sv
dv/tb_polar_cartesian_converter.sv
